FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the decimal text block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define NTD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ntd assertion failed");

// next-cycle implication, disabled during reset
`define NTD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ntd assertion failed");

`endif

FILE: sv/ntd_pkg.sv
// ----------------------------------------------------------------------------
// ntd_pkg
// Types, constants and helpers for the fixed-point to decimal text block.
// ----------------------------------------------------------------------------
package ntd_pkg;

	localparam int VALUE_W     = 64;
	localparam int FRAC_BITS   = 24;
	localparam int INT_W       = VALUE_W - FRAC_BITS;
	localparam int FD_W        = 30;
	localparam int PROD_W      = FRAC_BITS + FD_W;
	localparam int BCD_DIGITS  = 13;
	localparam int BCD_W       = 4 * BCD_DIGITS;
	localparam int PREC_LIMIT  = 9;
	localparam int MAX_BUFFER  = 64;
	localparam int LIM_W       = 6;
	localparam int CNT_W       = 6;

	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_PRECISION   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE = 1'b1;
	localparam logic [3:0] PRECISION_RST   = 4'd4;
	localparam logic [6:0] BUFFER_SIZE_RST = 7'd20;

	localparam logic [1:0] SPC_NUMBER = 2'd0;
	localparam logic [1:0] SPC_NAN    = 2'd1;
	localparam logic [1:0] SPC_INF    = 2'd2;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_N     = 8'h6E;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [1:0]                special;
	} ntd_in_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic       last;
	} ntd_out_t;

	// one converted number handed from the converter to the emitter
	typedef struct packed {
		logic [1:0]       special;
		logic             neg;
		logic [3:0]       prec;
		logic [LIM_W-1:0] lim;
		logic [BCD_W-1:0] int_bcd;
		logic [BCD_W-1:0] frac_bcd;
	} ntd_job_t;

	function automatic logic [FD_W-1:0] dec_pow(input logic [3:0] p);
		logic [FD_W-1:0] r;
		case (p)
			4'd0:    r = FD_W'(1);
			4'd1:    r = FD_W'(10);
			4'd2:    r = FD_W'(100);
			4'd3:    r = FD_W'(1000);
			4'd4:    r = FD_W'(10000);
			4'd5:    r = FD_W'(100000);
			4'd6:    r = FD_W'(1000000);
			4'd7:    r = FD_W'(10000000);
			4'd8:    r = FD_W'(100000000);
			default: r = FD_W'(1000000000);
		endcase
		return r;
	endfunction

	// letters of "inf" or "nan"; any code other than infinity spells nan
	function automatic logic [7:0] word_char(input logic [1:0] code, input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0:    r = (code == SPC_INF) ? CH_I : CH_N;
			2'd1:    r = (code == SPC_INF) ? CH_N : CH_A;
			default: r = (code == SPC_INF) ? CH_F : CH_N;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/number_to_decimal_text.sv
// ----------------------------------------------------------------------------
// number_to_decimal_text
// Prints a signed Q39.24 number as decimal ASCII, one character per transfer.
// ----------------------------------------------------------------------------
//  channel | direction | payload                         | handshake
//  in      | input     | ntd_in_t  {value, special}      | in_valid / in_stall
//  out     | output    | ntd_out_t {text_char, last}     | out_valid / out_stall
//  cfg     | input     | cfg_index, cfg_wdata            | cfg_we (write only)
//
//  Per number: capture, multiply-by-ten steps, rounding, BCD conversion and a
//  handoff; nan and inf skip to handoff. The emitter aligns digits, then sends
//  a character per cycle unless out_stall holds it, while the next number
//  converts; the handoff waits while the emitter is busy.
//  Reset sets precision to 4 and buffer_size to 20; no clearing pass.
//  out_stall holds the output register and pauses the character sequencer.
// ----------------------------------------------------------------------------
module number_to_decimal_text (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ntd_pkg::ntd_in_t               in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output ntd_pkg::ntd_out_t              out_data,
	input  logic                           cfg_we,
	input  logic [ntd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ntd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import ntd_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MULT  = 5'b00010,
		S_ROUND = 5'b00100,
		S_CONV  = 5'b01000,
		S_HAND  = 5'b10000
	} ntd_st_t;

	localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (FRAC_BITS - 1);

	ntd_st_t          state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [3:0]       precision_q;
	logic [6:0]       buffer_size_q;

	logic             neg_q;
	logic [1:0]       code_q;
	logic [3:0]       prec_q;
	logic [INT_W-1:0] ip_q;
	logic [PROD_W-1:0] prod_q;

	logic [VALUE_W-1:0] mag;
	logic [3:0]         prec_sat;
	logic [PROD_W:0]    rsum;
	logic [FD_W-1:0]    fd_raw, scale, fd_fix;
	logic               fd_carry;
	logic [INT_W-1:0]   ip_fix;
	logic [6:0]         size_cap;
	logic [LIM_W-1:0]   lim;
	logic               accept, conv_load, conv_step, start, emit_busy;
	logic [BCD_W-1:0]   int_bcd, frac_bcd;
	ntd_job_t           job;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	assign mag      = in_data.value[VALUE_W-1] ? (~in_data.value + VALUE_W'(1)) : in_data.value;
	assign prec_sat = (precision_q > 4'(PREC_LIMIT)) ? 4'(PREC_LIMIT) : precision_q;

	// round half up at the last printed digit; a full carry bumps the integer part
	assign rsum     = {1'b0, prod_q} + ROUND_HALF;
	assign fd_raw   = rsum[FRAC_BITS +: FD_W];
	assign scale    = dec_pow(prec_q);
	assign fd_carry = (fd_raw >= scale);
	assign fd_fix   = fd_carry ? fd_raw - scale : fd_raw;
	assign ip_fix   = ip_q + INT_W'(fd_carry);

	assign size_cap = (buffer_size_q > 7'(MAX_BUFFER)) ? 7'(MAX_BUFFER) : buffer_size_q;
	assign lim      = (size_cap == 7'd0) ? '0 : LIM_W'(size_cap - 7'd1);

	assign conv_load = (state_q == S_ROUND);
	assign conv_step = (state_q == S_CONV) && (cnt_q != '0);
	assign start     = (state_q == S_HAND) && !emit_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precision_q   <= PRECISION_RST;
			buffer_size_q <= BUFFER_SIZE_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_PRECISION)
				precision_q <= cfg_wdata[3:0];
			else if (cfg_index == CFG_BUFFER_SIZE)
				buffer_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q   <= CNT_W'(prec_sat);
						state_q <= (in_data.special != SPC_NUMBER) ? S_HAND : S_MULT;
					end
				end
				S_MULT: begin
					if (cnt_q == '0)
						state_q <= S_ROUND;
					else
						cnt_q <= cnt_q - CNT_W'(1);
				end
				S_ROUND: begin
					cnt_q   <= CNT_W'(INT_W);
					state_q <= S_CONV;
				end
				S_CONV: begin
					if (cnt_q == '0)
						state_q <= S_HAND;
					else
						cnt_q <= cnt_q - CNT_W'(1);
				end
				S_HAND: begin
					if (!emit_busy)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q  <= in_data.value[VALUE_W-1];
			code_q <= in_data.special;
			prec_q <= prec_sat;
			ip_q   <= mag[VALUE_W-1 -: INT_W];
			prod_q <= {{(PROD_W - FRAC_BITS){1'b0}}, mag[FRAC_BITS-1:0]};
		end else if (state_q == S_MULT && cnt_q != '0) begin
			// times ten as shift-and-add
			prod_q <= {prod_q[PROD_W-4:0], 3'd0} + {prod_q[PROD_W-2:0], 1'b0};
		end
	end

	ntd_dabble u_int_bcd (
		.clk  (clk),
		.load (conv_load),
		.step (conv_step),
		.bin  (ip_fix),
		.bcd  (int_bcd)
	);

	ntd_dabble u_frac_bcd (
		.clk  (clk),
		.load (conv_load),
		.step (conv_step),
		.bin  ({{(INT_W - FD_W){1'b0}}, fd_fix}),
		.bcd  (frac_bcd)
	);

	assign job = '{
		special:  code_q,
		neg:      neg_q,
		prec:     prec_q,
		lim:      lim,
		int_bcd:  int_bcd,
		frac_bcd: frac_bcd
	};

	ntd_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.job       (job),
		.busy      (emit_busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

FILE: sv/ntd_dabble.sv
// ----------------------------------------------------------------------------
// ntd_dabble
// Bit-serial binary to BCD converter (shift and add-3), one bit per step.
// ----------------------------------------------------------------------------
module ntd_dabble (
	input  logic                      clk,
	input  logic                      load,
	input  logic                      step,
	input  logic [ntd_pkg::INT_W-1:0] bin,
	output logic [ntd_pkg::BCD_W-1:0] bcd
);
	import ntd_pkg::*;

	logic [INT_W-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			adj[4*i +: 4] = (bcd_q[4*i +: 4] > 4'd4) ? bcd_q[4*i +: 4] + 4'd3
				: bcd_q[4*i +: 4];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bin_q <= bin;
			bcd_q <= '0;
		end else if (step) begin
			{bcd_q, bin_q} <= {adj[BCD_W-2:0], bin_q, 1'b0};
		end
	end

	assign bcd = bcd_q;

endmodule

FILE: sv/ntd_emit.sv
// ----------------------------------------------------------------------------
// ntd_emit
// Character sequencer: strips leading zeros, then shifts out the text one
// character per transfer through a registered output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntd_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  ntd_pkg::ntd_job_t job,
	output logic              busy,
	output logic              out_valid,
	input  logic              out_stall,
	output ntd_pkg::ntd_out_t out_data
);
	import ntd_pkg::*;

	typedef enum logic [6:0] {
		E_IDLE = 7'b0000001,
		E_NORM = 7'b0000010,
		E_SIGN = 7'b0000100,
		E_INT  = 7'b0001000,
		E_DOT  = 7'b0010000,
		E_FRAC = 7'b0100000,
		E_WORD = 7'b1000000
	} ntd_est_t;

	ntd_est_t         state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [3:0]       rem_q, rem_d;
	logic [3:0]       fsh_q, fsh_d;
	logic [1:0]       widx_q, widx_d;
	logic             ovalid_q, ovalid_d;

	logic [BCD_W-1:0] int_q, int_d;
	logic [BCD_W-1:0] frac_q, frac_d;
	logic             neg_q;
	logic [1:0]       code_q;
	logic [3:0]       prec_q;
	logic [LIM_W-1:0] lim_q;
	ntd_out_t         odata_q, odata_d;

	logic [3:0] int_top, frac_top;
	logic [7:0] ch;
	logic       nat_end, emitting, emit_go, is_last, int_zero_lead;

	assign int_top  = int_q[BCD_W-1 -: 4];
	assign frac_top = frac_q[BCD_W-1 -: 4];
	assign int_zero_lead = (rem_q > 4'd1) && (int_top == 4'd0);

	always_comb begin
		ch      = CH_ZERO;
		nat_end = 1'b0;
		case (state_q)
			E_SIGN: ch = CH_MINUS;
			E_INT: begin
				ch      = CH_ZERO + {4'd0, int_top};
				nat_end = (rem_q == 4'd1) && (prec_q == 4'd0);
			end
			E_DOT:  ch = CH_DOT;
			E_FRAC: begin
				ch      = CH_ZERO + {4'd0, frac_top};
				nat_end = (rem_q == 4'd1);
			end
			E_WORD: begin
				ch      = word_char(code_q, widx_q);
				nat_end = (widx_q == 2'd2);
			end
			default: ;
		endcase
	end

	assign emitting = state_q inside {E_SIGN, E_INT, E_DOT, E_FRAC, E_WORD};
	assign emit_go  = emitting && (!ovalid_q || !out_stall);
	assign is_last  = nat_end || ((cnt_q + CNT_W'(1)) == CNT_W'(lim_q));

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		rem_d    = rem_q;
		fsh_d    = fsh_q;
		widx_d   = widx_q;
		int_d    = int_q;
		frac_d   = frac_q;
		ovalid_d = ovalid_q;
		odata_d  = odata_q;

		if (emit_go) begin
			ovalid_d = 1'b1;
			odata_d  = '{text_char: ch, last: is_last};
		end else if (!out_stall) begin
			ovalid_d = 1'b0;
		end

		if (start) begin
			int_d  = job.int_bcd;
			frac_d = job.frac_bcd;
			cnt_d  = '0;
			widx_d = '0;
			rem_d  = 4'(BCD_DIGITS);
			fsh_d  = 4'(BCD_DIGITS) - job.prec;
			if (job.lim == '0)
				state_d = E_IDLE;
			else if (job.special != SPC_NUMBER)
				state_d = E_WORD;
			else
				state_d = E_NORM;
		end else begin
			case (state_q)
				E_NORM: begin
					// drop leading zero digits and align the fraction digits to the top
					if (int_zero_lead) begin
						int_d = {int_q[BCD_W-5:0], 4'd0};
						rem_d = rem_q - 4'd1;
					end
					if (fsh_q != 4'd0) begin
						frac_d = {frac_q[BCD_W-5:0], 4'd0};
						fsh_d  = fsh_q - 4'd1;
					end
					if (!int_zero_lead && fsh_q == 4'd0)
						state_d = neg_q ? E_SIGN : E_INT;
				end
				default: begin
					if (emit_go) begin
						cnt_d = cnt_q + CNT_W'(1);
						case (state_q)
							E_SIGN: state_d = E_INT;
							E_INT: begin
								int_d = {int_q[BCD_W-5:0], 4'd0};
								if (rem_q == 4'd1) begin
									rem_d   = prec_q;
									state_d = E_DOT;
								end else begin
									rem_d = rem_q - 4'd1;
								end
							end
							E_DOT:  state_d = E_FRAC;
							E_FRAC: begin
								frac_d = {frac_q[BCD_W-5:0], 4'd0};
								rem_d  = rem_q - 4'd1;
							end
							E_WORD: widx_d = widx_q + 2'd1;
							default: ;
						endcase
						if (is_last)
							state_d = E_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			cnt_q    <= '0;
			rem_q    <= '0;
			fsh_q    <= '0;
			widx_q   <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			rem_q    <= rem_d;
			fsh_q    <= fsh_d;
			widx_q   <= widx_d;
			ovalid_q <= ovalid_d;
		end
	end

	always_ff @(posedge clk) begin
		int_q   <= int_d;
		frac_q  <= frac_d;
		odata_q <= odata_d;
		if (start) begin
			neg_q  <= job.neg;
			code_q <= job.special;
			prec_q <= job.prec;
			lim_q  <= job.lim;
		end
	end

	assign busy      = (state_q != E_IDLE);
	assign out_valid = ovalid_q;
	assign out_data  = odata_q;

	`NTD_ASSERT_IMP(a_start_when_idle, clk, arst_n, start, state_q == E_IDLE)
	`NTD_ASSERT_IMP(a_within_limit, clk, arst_n, emit_go, cnt_q < CNT_W'(lim_q))
	`NTD_ASSERT_NXT(a_last_ends_text, clk, arst_n, emit_go && is_last, state_q == E_IDLE)

endmodule
